// ===== hdl/olmtf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ordered list move-to-front block.
// No dependencies; used by olmtf_cell and ordered_list_move_to_front.

package olmtf_pkg;

    // Field widths of the stream payloads.
    localparam int ACTION_W   = 3;
    localparam int POSITION_W = 6;
    localparam int VALUE_W    = 16;
    localparam int COUNT_W    = 6;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    // Read-out never emits more than this many results per item.
    localparam int MAX_RESULTS = 32;
    localparam int RES_W       = 6;

    // Index bus wide enough for the largest supported list (1024 entries).
    localparam int IDX_W = 10;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND  = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_DELETE  = 3'd2,
        ACT_MOVE    = 3'd3,
        ACT_REVERSE = 3'd4,
        ACT_READ    = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_RANGE  = 2'd2,
        STAT_NODATA = 2'd3
    } status_t;

    // What every cell of the chain does in one cycle.
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,  // keep value
        OP_PUSH   = 3'd1,  // take left neighbor (head takes new handle)
        OP_WRITE  = 3'd2,  // cell at idx takes new handle
        OP_PULL   = 3'd3,  // cells at or above idx take right neighbor
        OP_ROTATE = 3'd4   // below idx take right neighbor, idx takes head
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
    } cell_ctrl_t;

endpackage

// ===== hdl/olmtf_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list chain: holds a handle, swaps with neighbors.
// Depends on olmtf_pkg.

module olmtf_cell #(
    parameter int INDEX        = 0,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                     aclk,
    input  olmtf_pkg::cell_ctrl_t    ctrl,
    input  logic [HANDLE_WIDTH-1:0]  left_in,
    input  logic [HANDLE_WIDTH-1:0]  right_in,
    input  logic [HANDLE_WIDTH-1:0]  front_in,
    input  logic [HANDLE_WIDTH-1:0]  load_val,
    output logic [HANDLE_WIDTH-1:0]  value
);

    localparam logic [olmtf_pkg::IDX_W-1:0] MY_IDX = olmtf_pkg::IDX_W'(INDEX);

    logic [HANDLE_WIDTH-1:0] data_reg;
    logic [HANDLE_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            olmtf_pkg::OP_PUSH: begin
                data_next = left_in;
            end
            olmtf_pkg::OP_WRITE: begin
                if (ctrl.idx == MY_IDX) data_next = load_val;
            end
            olmtf_pkg::OP_PULL: begin
                if (MY_IDX >= ctrl.idx) data_next = right_in;
            end
            olmtf_pkg::OP_ROTATE: begin
                if (MY_IDX < ctrl.idx) data_next = right_in;
                else if (MY_IDX == ctrl.idx) data_next = front_in;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign value = data_reg;

endmodule

// ===== hdl/ordered_list_move_to_front.sv =====
`timescale 1ns / 1ps
// Top level: ordered handle list with move-to-front, built as a chain of cells.
// Depends on olmtf_pkg and olmtf_cell.
//
//  Channel | Dir | Ports                            | Payload
//  --------+-----+----------------------------------+--------------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata[31:0]  | action, position, entry_value
//  m_      | out | m_tvalid m_tready m_tdata[31:0]  | entry_value_res, entry_position,
//          |     | m_tlast                          | entry_count, status; tlast = last
//
//  Append, insert, delete, rejected actions and unused codes: one per cycle, as long as
//  the output register is free. Move, reverse and read run as steps in the run state.
//  All multi-cycle work goes through the single rotate path of the cell chain, one
//  rotation step per cycle; a read step also waits for the output register.
//  Reset (aresetn low, synchronous) empties the list; cell contents are not cleared.
//  m_tready low only stalls: nothing is accepted until the output register frees up.

module ordered_list_move_to_front #(
    parameter int DEPTH        = 32,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: action[2:0], position[8:3], entry_value[24:9], zero pad
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [olmtf_pkg::S_TDATA_W-1:0]    s_tdata,
    // m_tdata: entry_value_res[15:0], entry_position[21:16], entry_count[27:22],
    //          status[29:28], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [olmtf_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > olmtf_pkg::POSITION_W) ? CW : olmtf_pkg::POSITION_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // ---------------------------------------------------------------- input fields
    logic [olmtf_pkg::ACTION_W-1:0]   s_action;
    logic [olmtf_pkg::POSITION_W-1:0] s_position;
    logic [olmtf_pkg::VALUE_W-1:0]    s_entry_value;
    logic [63:0]                      val_wide;
    logic [HANDLE_WIDTH-1:0]          val_h;

    assign s_action      = s_tdata[2:0];
    assign s_position    = s_tdata[8:3];
    assign s_entry_value = s_tdata[24:9];
    assign val_wide      = 64'(s_entry_value);
    assign val_h         = val_wide[HANDLE_WIDTH-1:0];

    // ---------------------------------------------------------------- state
    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [IW-1:0]                  rot_idx_reg, rot_idx_next;   // rotate boundary
    logic [CW-1:0]                  steps_reg, steps_next;       // rotations left
    logic [olmtf_pkg::RES_W-1:0]    emit_reg, emit_next;         // read results left
    logic [olmtf_pkg::RES_W-1:0]    rd_pos_reg, rd_pos_next;
    logic                           rev_reg, rev_next;           // boundary walks down

    // output register
    logic                               m_valid_reg, m_valid_next;
    logic [olmtf_pkg::VALUE_W-1:0]      m_value_reg, m_value_next;
    logic [olmtf_pkg::POSITION_W-1:0]   m_pos_reg, m_pos_next;
    logic [olmtf_pkg::COUNT_W-1:0]      m_cnt_reg, m_cnt_next;
    olmtf_pkg::status_t                 m_status_reg, m_status_next;
    logic                               m_last_reg, m_last_next;

    // ---------------------------------------------------------------- cell chain
    olmtf_pkg::cell_ctrl_t   cell_ctrl;
    logic [HANDLE_WIDTH-1:0] cell_q [DEPTH];
    logic [63:0]             front_wide;

    genvar g;
    for (g = 0; g < DEPTH; g++) begin : g_cell
        logic [HANDLE_WIDTH-1:0] left_d;
        logic [HANDLE_WIDTH-1:0] right_d;

        if (g == 0) begin : g_head
            assign left_d = val_h;
        end else begin : g_body
            assign left_d = cell_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_d = cell_q[g];
        end else begin : g_inner
            assign right_d = cell_q[g+1];
        end

        olmtf_cell #(
            .INDEX        (g),
            .HANDLE_WIDTH (HANDLE_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .left_in  (left_d),
            .right_in (right_d),
            .front_in (cell_q[0]),
            .load_val (val_h),
            .value    (cell_q[g])
        );
    end

    assign front_wide = 64'(cell_q[0]);

    // ---------------------------------------------------------------- decode
    logic              out_free;
    logic              accept;
    logic              full;
    logic              pos_bad;
    logic [CMPW-1:0]   n_ext, cnt_ext, rd_lim, rd_m;
    logic [IW-1:0]     n_idx, cnt_idx, last_idx;
    logic              step_en;
    logic              res_now;
    olmtf_pkg::status_t res_status;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign n_ext    = CMPW'(s_position);
    assign cnt_ext  = CMPW'(count_reg);
    assign full     = (count_reg == CW'(DEPTH));
    assign pos_bad  = (n_ext == '0) || (n_ext > cnt_ext);
    assign n_idx    = IW'(n_ext - CMPW'(1));
    assign cnt_idx  = IW'(count_reg);
    assign last_idx = IW'(cnt_ext - CMPW'(1));
    assign rd_lim   = (n_ext < cnt_ext) ? n_ext : cnt_ext;
    assign rd_m     = (rd_lim > CMPW'(olmtf_pkg::MAX_RESULTS)) ?
                      CMPW'(olmtf_pkg::MAX_RESULTS) : rd_lim;
    assign step_en  = (emit_reg == '0) || out_free;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rot_idx_next  = rot_idx_reg;
        steps_next    = steps_reg;
        emit_next     = emit_reg;
        rd_pos_next   = rd_pos_reg;
        rev_next      = rev_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_pos_next    = m_pos_reg;
        m_cnt_next    = m_cnt_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        cell_ctrl     = '{op: olmtf_pkg::OP_HOLD, idx: '0};
        res_now       = 1'b0;
        res_status    = olmtf_pkg::STAT_OK;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_now = 1'b1;
                    case (olmtf_pkg::action_t'(s_action))
                        olmtf_pkg::ACT_APPEND: begin
                            if (full) begin
                                res_status = olmtf_pkg::STAT_FULL;
                            end else begin
                                cell_ctrl  = '{op: olmtf_pkg::OP_WRITE,
                                               idx: olmtf_pkg::IDX_W'(cnt_idx)};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        olmtf_pkg::ACT_INSERT: begin
                            if (full) begin
                                res_status = olmtf_pkg::STAT_FULL;
                            end else begin
                                cell_ctrl  = '{op: olmtf_pkg::OP_PUSH, idx: '0};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        olmtf_pkg::ACT_DELETE: begin
                            if (pos_bad) begin
                                res_status = olmtf_pkg::STAT_RANGE;
                            end else begin
                                cell_ctrl  = '{op: olmtf_pkg::OP_PULL,
                                               idx: olmtf_pkg::IDX_W'(n_idx)};
                                count_next = count_reg - CW'(1);
                            end
                        end
                        olmtf_pkg::ACT_MOVE: begin
                            if (pos_bad) begin
                                res_status = olmtf_pkg::STAT_RANGE;
                            end else if (n_ext > CMPW'(1)) begin
                                // rotate the first n cells left n-1 times
                                state_next   = ST_RUN;
                                rot_idx_next = n_idx;
                                steps_next   = CW'(n_ext - CMPW'(1));
                                emit_next    = '0;
                                rev_next     = 1'b0;
                            end
                        end
                        olmtf_pkg::ACT_REVERSE: begin
                            if (cnt_ext > CMPW'(1)) begin
                                // head sinks to a boundary that walks toward the front
                                state_next   = ST_RUN;
                                rot_idx_next = last_idx;
                                steps_next   = count_reg - CW'(1);
                                emit_next    = '0;
                                rev_next     = 1'b1;
                            end
                        end
                        olmtf_pkg::ACT_READ: begin
                            if (rd_m == '0) begin
                                res_status = olmtf_pkg::STAT_NODATA;
                            end else begin
                                // full rotation of the list, head emitted in each of the first rd_m steps
                                res_now      = 1'b0;
                                state_next   = ST_RUN;
                                rot_idx_next = last_idx;
                                steps_next   = count_reg;
                                emit_next    = olmtf_pkg::RES_W'(rd_m);
                                rd_pos_next  = olmtf_pkg::RES_W'(1);
                                rev_next     = 1'b0;
                            end
                        end
                        default: begin
                            res_status = olmtf_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (step_en) begin
                    cell_ctrl  = '{op: olmtf_pkg::OP_ROTATE,
                                   idx: olmtf_pkg::IDX_W'(rot_idx_reg)};
                    steps_next = steps_reg - CW'(1);
                    if (rev_reg) rot_idx_next = rot_idx_reg - IW'(1);
                    if (emit_reg != '0) begin
                        m_valid_next  = 1'b1;
                        m_value_next  = front_wide[olmtf_pkg::VALUE_W-1:0];
                        m_pos_next    = rd_pos_reg;
                        m_cnt_next    = cnt_ext[olmtf_pkg::COUNT_W-1:0];
                        m_status_next = olmtf_pkg::STAT_OK;
                        m_last_next   = (emit_reg == olmtf_pkg::RES_W'(1));
                        emit_next     = emit_reg - olmtf_pkg::RES_W'(1);
                        rd_pos_next   = rd_pos_reg + olmtf_pkg::RES_W'(1);
                    end
                    if (steps_reg == CW'(1)) state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // single status result, count taken after the action
        if (res_now) begin
            m_valid_next  = 1'b1;
            m_value_next  = '0;
            m_pos_next    = '0;
            m_cnt_next    = olmtf_pkg::COUNT_W'(count_next);
            m_status_next = res_status;
            m_last_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            steps_reg   <= '0;
            emit_reg    <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            steps_reg   <= steps_next;
            emit_reg    <= emit_next;
            rev_reg     <= rev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        rot_idx_reg  <= rot_idx_next;
        rd_pos_reg   <= rd_pos_next;
        m_value_reg  <= m_value_next;
        m_pos_reg    <= m_pos_next;
        m_cnt_reg    <= m_cnt_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_status_reg, m_cnt_reg, m_pos_reg, m_value_reg};

    // ---------------------------------------------------------------- checks
    // list never grows past its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds capacity");

    // a non-final result only comes from a read-out and carries a position
    a_mid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |->
            (m_status_reg == olmtf_pkg::STAT_OK && m_pos_reg != '0))
        else $error("non-final result outside read-out");

    // any action other than a read answers in the next cycle
    a_quick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_action != olmtf_pkg::ACT_READ) |=> m_tvalid)
        else $error("missing status result");

    // read results still owed never outnumber rotation steps left
    a_emit_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (CMPW'(emit_reg) <= CMPW'(steps_reg)))
        else $error("read-out outruns rotation");

endmodule
